### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// when ante holds, cons must hold at the same edge
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/ttdp_pkg.sv
// ----------------------------------------------------------------------------
// ttdp_pkg
// Widths, codes and shared types of the touch pad tap/drag pointer.
// ----------------------------------------------------------------------------
package ttdp_pkg;

    localparam int COORD_BITS = 10;
    localparam int PEN_W      = 10;
    localparam int TICK_W     = 32;
    localparam int TMAX_W     = 16;
    localparam int TMOVE_W    = 10;
    localparam int THR_W      = 16;
    localparam int DELTA_W    = 12;
    localparam int BTN_W      = 2;
    localparam int CMD_W      = 3;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // signed coordinate difference and speed datapath
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int TS_W    = COORD_BITS + 1;
    localparam int DIST_W  = 2 * COORD_BITS + 1;
    localparam int TSQ_W   = 2 * TS_W;
    localparam int ACC_W   = TSQ_W + THR_W;
    localparam int MP_W    = (THR_W > TS_W) ? THR_W : TS_W;
    localparam int CNT_W   = $clog2(MP_W + 1);

    // stream packing
    localparam int IN_X_LSB     = 0;
    localparam int IN_Y_LSB     = IN_X_LSB + PEN_W;
    localparam int IN_T_LSB     = IN_Y_LSB + PEN_W;
    localparam int IN_CH_LSB    = IN_T_LSB + TICK_W;
    localparam int IN_EN_LSB    = IN_CH_LSB + BTN_W;
    localparam int IN_FIELDS_W  = IN_EN_LSB + 1;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DX_LSB   = 0;
    localparam int OUT_DY_LSB   = OUT_DX_LSB + DELTA_W;
    localparam int OUT_BTN_LSB  = OUT_DY_LSB + DELTA_W;
    localparam int OUT_FIELDS_W = OUT_BTN_LSB + BTN_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_PEN_DOWN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PEN_MOVE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEN_UP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_IDLE_SAMPLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SELECT      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DRAG_MODE   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_MOVE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

    localparam logic [BTN_W-1:0] BTN_NONE = 2'd0;
    localparam logic [BTN_W-1:0] BTN_LEFT = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MOVE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_THR = 2'd2;

    localparam logic [TMAX_W-1:0]  TAP_TICKS_RST = 16'd50;
    localparam logic [TMOVE_W-1:0] TAP_MOVE_RST  = 10'd10;
    localparam logic [THR_W-1:0]   SPEED_THR_RST = 16'd25;

    typedef struct packed {
        logic             start;
        logic             clear;
        logic [ACC_W-1:0] mcand;
        logic [MP_W-1:0]  mplier;
        logic [CNT_W-1:0] steps;
    } mul_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ACC_W-1:0] acc;
    } mul_sts_t;

    // magnitude of a two's complement coordinate difference
    function automatic logic [COORD_BITS-1:0] mag(input logic [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] n;
        n = -d;
        return d[DIFF_W-1] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

endpackage

### rtl/ttdp_mul.sv
// ----------------------------------------------------------------------------
// ttdp_mul
// Shift-add multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttdp_mul
    import ttdp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_cmd_t cmd,
    output mul_sts_t sts
);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [ACC_W-1:0] mcand_reg;
    logic [MP_W-1:0]  mplier_reg;
    logic [ACC_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cmd.start)
                cnt_reg <= cmd.steps;
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mcand_reg  <= cmd.mcand;
            mplier_reg <= cmd.mplier;
            if (cmd.clear)
                acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MP_W-1:1]};
        end
    end

    assign sts.busy = (cnt_reg != '0);
    assign sts.done = done_reg;
    assign sts.acc  = acc_reg;

    `ASSERT_IMPLIES(a_done_idle, done_reg, cnt_reg == '0, "mul done while still stepping")

endmodule

### rtl/ttdp_speed.sv
// ----------------------------------------------------------------------------
// ttdp_speed
// Speed test dx^2+dy^2 >= thr*t^2 sequenced over the serial multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttdp_speed
    import ttdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIFF_W-1:0] dx,
    input  logic [DIFF_W-1:0] dy,
    input  logic [TICK_W-1:0] t,
    input  logic [THR_W-1:0]  thr,
    output logic              done,
    output logic              fast
);

    typedef enum logic [2:0] {SP_IDLE, SP_DX, SP_DY, SP_T, SP_THR} sp_state_t;

    sp_state_t state_reg;
    logic      done_reg;
    logic      fast_reg;

    logic [COORD_BITS-1:0] my_reg;
    logic [TS_W-1:0]       ts_reg;
    logic [DIST_W-1:0]     dist2_reg;

    logic [COORD_BITS-1:0] mx;
    logic [COORD_BITS-1:0] my;
    logic [TICK_W-1:0]     t_eff;
    logic                  t_big;
    mul_cmd_t              mcmd;
    mul_sts_t              msts;

    assign mx    = mag(dx);
    assign my    = mag(dy);
    assign t_eff = (t == '0) ? TICK_W'(1) : t;
    // t^2 beyond the largest distance square: never fast unless thr is zero
    assign t_big = |t_eff[TICK_W-1:TS_W];

    ttdp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mcmd),
        .sts   (msts)
    );

    always_comb
    begin
        mcmd = '0;
        case (state_reg)
            SP_IDLE:
            begin
                if (start && thr != '0 && !t_big)
                begin
                    mcmd.start  = 1'b1;
                    mcmd.clear  = 1'b1;
                    mcmd.mcand  = ACC_W'(mx);
                    mcmd.mplier = MP_W'(mx);
                    mcmd.steps  = CNT_W'(COORD_BITS);
                end
            end
            SP_DX:
            begin
                if (msts.done)
                begin
                    mcmd.start  = 1'b1;
                    mcmd.mcand  = ACC_W'(my_reg);
                    mcmd.mplier = MP_W'(my_reg);
                    mcmd.steps  = CNT_W'(COORD_BITS);
                end
            end
            SP_DY:
            begin
                if (msts.done)
                begin
                    mcmd.start  = 1'b1;
                    mcmd.clear  = 1'b1;
                    mcmd.mcand  = ACC_W'(ts_reg);
                    mcmd.mplier = MP_W'(ts_reg);
                    mcmd.steps  = CNT_W'(TS_W);
                end
            end
            SP_T:
            begin
                if (msts.done)
                begin
                    mcmd.start  = 1'b1;
                    mcmd.clear  = 1'b1;
                    mcmd.mcand  = msts.acc;
                    mcmd.mplier = MP_W'(thr);
                    mcmd.steps  = CNT_W'(THR_W);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SP_IDLE;
            done_reg  <= 1'b0;
            fast_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                SP_IDLE:
                begin
                    if (start)
                    begin
                        if (thr == '0)
                        begin
                            done_reg <= 1'b1;
                            fast_reg <= 1'b1;
                        end
                        else if (t_big)
                        begin
                            done_reg <= 1'b1;
                            fast_reg <= 1'b0;
                        end
                        else
                            state_reg <= SP_DX;
                    end
                end
                SP_DX:
                    if (msts.done)
                        state_reg <= SP_DY;
                SP_DY:
                    if (msts.done)
                        state_reg <= SP_T;
                SP_T:
                    if (msts.done)
                        state_reg <= SP_THR;
                SP_THR:
                begin
                    if (msts.done)
                    begin
                        fast_reg  <= (ACC_W'(dist2_reg) >= msts.acc);
                        done_reg  <= 1'b1;
                        state_reg <= SP_IDLE;
                    end
                end
                default:
                    state_reg <= SP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SP_IDLE && start)
        begin
            my_reg <= my;
            ts_reg <= t_eff[TS_W-1:0];
        end
        if (state_reg == SP_DY && msts.done)
            dist2_reg <= msts.acc[DIST_W-1:0];
    end

    assign done = done_reg;
    assign fast = fast_reg;

    `ASSERT_IMPLIES(a_start_when_free, mcmd.start, !msts.busy, "mul started while busy")

endmodule

### rtl/touchpad_tap_drag_pointer.sv
// ----------------------------------------------------------------------------
// touchpad_tap_drag_pointer
// Pen events in, relative mouse reports (move, click, press, release) out.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                     | beat
//  ----------+-----+-------------------------------+-----------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | pen event, command in tuser
//  m_axis    | out | m_axis_tvalid / m_axis_tready | report, kind in tuser
//  cfg       | in  | cfg_valid / cfg_ready         | register index + data
//
//  One event at a time. Pen up, select and drag mode events that make a
//  report are staged in ST_EVAL and then moved to the output register; a
//  pen down sends no report. A move or idle sample that sends motion runs
//  the speed test through the bit-serial shift-add multiplier:
//  3*COORD_BITS+1+16 steps (47 at 10 bit); a speed threshold of zero or a
//  gap of 2^(COORD_BITS+1) ticks or more skips the multiplies.
//  The output register stalls the event path only when a new report finds
//  the previous one still untaken. Reset (rst_n, async low) restores the
//  register defaults and the idle pointer state; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module touchpad_tap_drag_pointer
    import ttdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pen_x[9:0], pen_y[19:10], now_ticks[51:20], button_choice[53:52],
    // drag_enable[54], zero pad[55]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // move_dx[11:0], move_dy[23:12], button_number[25:24], zero pad[31:26]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // report_kind[1:0]
    output logic [KIND_W-1:0]     m_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_EVAL, ST_SPEED, ST_EMIT} state_t;

    state_t state_reg;

    // configuration
    logic [TMAX_W-1:0]  tap_ticks_reg;
    logic [TMOVE_W-1:0] tap_move_reg;
    logic [THR_W-1:0]   speed_thr_reg;

    // pointer state
    logic                  tracking_reg;
    logic                  has_moved_reg;
    logic [COORD_BITS-1:0] anchor_x_reg;
    logic [COORD_BITS-1:0] anchor_y_reg;
    logic [TICK_W-1:0]     down_time_reg;
    logic [TICK_W-1:0]     last_send_reg;
    logic                  drag_mode_reg;
    logic                  dragging_reg;
    logic [BTN_W-1:0]      chosen_reg;

    // captured event
    logic [CMD_W-1:0]      cmd_reg;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic [TICK_W-1:0]     now_reg;
    logic [BTN_W-1:0]      choice_reg;
    logic                  enable_reg;

    // staged report and output register
    logic [KIND_W-1:0]     res_kind_reg;
    logic [DELTA_W-1:0]    res_dx_reg;
    logic [DELTA_W-1:0]    res_dy_reg;
    logic [BTN_W-1:0]      res_btn_reg;
    logic                  out_valid_reg;
    logic [KIND_W-1:0]     out_kind_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                        in_beat;
    logic [PEN_W+COORD_BITS-1:0] pen_x_ext;
    logic [PEN_W+COORD_BITS-1:0] pen_y_ext;
    logic [DIFF_W-1:0]           dx_w;
    logic [DIFF_W-1:0]           dy_w;
    logic [TICK_W-1:0]           elapsed;
    logic [TICK_W-1:0]           since_send;
    logic                        time_ok;
    logic                        within_tap;
    logic                        send_motion;
    logic                        speed_start;
    logic                        speed_done;
    logic                        speed_fast;
    logic signed [DIFF_W:0]      ddx;
    logic signed [DIFF_W:0]      ddy;
    logic signed [TICK_W-1:0]    ddx_ext;
    logic signed [TICK_W-1:0]    ddy_ext;
    logic                        out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // only the low COORD_BITS of the pen position count
    assign pen_x_ext = {{COORD_BITS{1'b0}}, s_axis_tdata[IN_X_LSB +: PEN_W]};
    assign pen_y_ext = {{COORD_BITS{1'b0}}, s_axis_tdata[IN_Y_LSB +: PEN_W]};

    // tap window and motion test on the captured event
    assign dx_w       = {1'b0, px_reg} - {1'b0, anchor_x_reg};
    assign dy_w       = {1'b0, py_reg} - {1'b0, anchor_y_reg};
    assign elapsed    = now_reg - down_time_reg;
    assign since_send = now_reg - last_send_reg;
    assign time_ok    = (elapsed[TICK_W-1:TMAX_W] == '0)
                     && (elapsed[TMAX_W-1:0] <= tap_ticks_reg);
    assign within_tap = time_ok
                     && (TICK_W'(mag(dx_w)) <= TICK_W'(tap_move_reg))
                     && (TICK_W'(mag(dy_w)) <= TICK_W'(tap_move_reg));
    assign send_motion = tracking_reg && (has_moved_reg || !within_tap);
    assign speed_start = (state_reg == ST_EVAL)
                      && (cmd_reg == CMD_PEN_MOVE || cmd_reg == CMD_IDLE_SAMPLE)
                      && send_motion;

    ttdp_speed u_speed (
        .clk   (clk),
        .rst_n (rst_n),
        .start (speed_start),
        .dx    (dx_w),
        .dy    (dy_w),
        .t     (since_send),
        .thr   (speed_thr_reg),
        .done  (speed_done),
        .fast  (speed_fast)
    );

    // doubled on fast motion; reported in the low DELTA_W bits
    assign ddx     = speed_fast ? $signed({dx_w, 1'b0}) : $signed({dx_w[DIFF_W-1], dx_w});
    assign ddy     = speed_fast ? $signed({dy_w, 1'b0}) : $signed({dy_w[DIFF_W-1], dy_w});
    assign ddx_ext = TICK_W'(ddx);
    assign ddy_ext = TICK_W'(ddy);

    assign out_free = !out_valid_reg || m_axis_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_ticks_reg <= TAP_TICKS_RST;
            tap_move_reg  <= TAP_MOVE_RST;
            speed_thr_reg <= SPEED_THR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TAP_TICKS: tap_ticks_reg <= cfg_data[TMAX_W-1:0];
                REG_TAP_MOVE:  tap_move_reg  <= cfg_data[TMOVE_W-1:0];
                REG_SPEED_THR: speed_thr_reg <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // event capture
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cmd_reg    <= s_axis_tuser;
            px_reg     <= pen_x_ext[COORD_BITS-1:0];
            py_reg     <= pen_y_ext[COORD_BITS-1:0];
            now_reg    <= s_axis_tdata[IN_T_LSB +: TICK_W];
            choice_reg <= s_axis_tdata[IN_CH_LSB +: BTN_W];
            enable_reg <= s_axis_tdata[IN_EN_LSB];
        end
    end

    // event sequencer, pointer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tracking_reg  <= 1'b0;
            has_moved_reg <= 1'b0;
            anchor_x_reg  <= '0;
            anchor_y_reg  <= '0;
            down_time_reg <= '0;
            last_send_reg <= '0;
            drag_mode_reg <= 1'b0;
            dragging_reg  <= 1'b0;
            chosen_reg    <= BTN_LEFT;
            res_kind_reg  <= KIND_MOVE;
            res_dx_reg    <= '0;
            res_dy_reg    <= '0;
            res_btn_reg   <= BTN_NONE;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_MOVE;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                    if (in_beat)
                        state_reg <= ST_EVAL;

                ST_EVAL:
                begin
                    state_reg   <= ST_IDLE;
                    res_dx_reg  <= '0;
                    res_dy_reg  <= '0;
                    case (cmd_reg)
                        CMD_PEN_DOWN:
                        begin
                            // a pen down while tracking restarts the stroke
                            anchor_x_reg  <= px_reg;
                            anchor_y_reg  <= py_reg;
                            down_time_reg <= now_reg;
                            last_send_reg <= now_reg;
                            tracking_reg  <= 1'b1;
                            has_moved_reg <= 1'b0;
                        end
                        CMD_PEN_MOVE, CMD_IDLE_SAMPLE:
                            if (send_motion)
                                state_reg <= ST_SPEED;
                        CMD_PEN_UP:
                        begin
                            if (tracking_reg)
                            begin
                                tracking_reg <= 1'b0;
                                if (!has_moved_reg && within_tap)
                                begin
                                    state_reg   <= ST_EMIT;
                                    res_btn_reg <= chosen_reg;
                                    if (drag_mode_reg && dragging_reg)
                                    begin
                                        // tap while held: release ends drag mode
                                        res_kind_reg  <= KIND_RELEASE;
                                        dragging_reg  <= 1'b0;
                                        drag_mode_reg <= 1'b0;
                                        chosen_reg    <= BTN_LEFT;
                                    end
                                    else if (drag_mode_reg)
                                    begin
                                        res_kind_reg <= KIND_PRESS;
                                        dragging_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        res_kind_reg <= KIND_CLICK;
                                        chosen_reg   <= BTN_LEFT;
                                    end
                                end
                            end
                        end
                        CMD_SELECT:
                        begin
                            if (dragging_reg)
                            begin
                                state_reg     <= ST_EMIT;
                                res_kind_reg  <= KIND_RELEASE;
                                res_btn_reg   <= chosen_reg;
                                dragging_reg  <= 1'b0;
                                drag_mode_reg <= 1'b0;
                            end
                            chosen_reg <= (choice_reg == BTN_NONE) ? BTN_LEFT : choice_reg;
                        end
                        CMD_DRAG_MODE:
                        begin
                            if (!enable_reg && dragging_reg)
                            begin
                                state_reg    <= ST_EMIT;
                                res_kind_reg <= KIND_RELEASE;
                                res_btn_reg  <= chosen_reg;
                                dragging_reg <= 1'b0;
                                chosen_reg   <= BTN_LEFT;
                            end
                            drag_mode_reg <= enable_reg;
                        end
                        default: ;
                    endcase
                end

                ST_SPEED:
                begin
                    if (speed_done)
                    begin
                        anchor_x_reg  <= px_reg;
                        anchor_y_reg  <= py_reg;
                        last_send_reg <= now_reg;
                        has_moved_reg <= 1'b1;
                        res_kind_reg  <= KIND_MOVE;
                        res_dx_reg    <= ddx_ext[DELTA_W-1:0];
                        res_dy_reg    <= ddy_ext[DELTA_W-1:0];
                        res_btn_reg   <= BTN_NONE;
                        // a zero delta still moves the anchor but sends nothing
                        if (dx_w == '0 && dy_w == '0)
                            state_reg <= ST_IDLE;
                        else
                            state_reg <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= res_kind_reg;
                        out_data_reg  <= OUT_DATA_W'({res_btn_reg, res_dy_reg, res_dx_reg});
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = out_data_reg;

    `ASSERT_IMPLIES(a_drag_needs_mode, dragging_reg, drag_mode_reg, "dragging outside drag mode")
    `ASSERT_ALWAYS(a_button_valid, chosen_reg != BTN_NONE, "no button chosen")
    `ASSERT_IMPLIES(a_emit_no_overrun, state_reg == ST_EMIT && out_free, !speed_start,
        "speed test started while a report is staged")

endmodule
